// ===== hw/rtl/sti_pkg.sv =====
// Shared constants and types for the segment/triangle intersection core.
// No dependencies; every other file of the block imports this package.
package sti_pkg;

  localparam int STI_COORD_WIDTH = 16;
  localparam int STI_THR_WIDTH = 32;
  localparam logic [STI_THR_WIDTH-1:0] STI_THR_RESET = 32'd1;

  typedef enum logic [1:0] {
    RSN_HIT      = 2'd0,
    RSN_PARALLEL = 2'd1,
    RSN_OUT_BARY = 2'd2,
    RSN_OUT_SEG  = 2'd3
  } sti_reason_t;

  // Slots of the four difference vectors carried down the pipe
  localparam int DI_E1 = 0;
  localparam int DI_E2 = 1;
  localparam int DI_T  = 2;
  localparam int DI_D  = 3;

  // Slots of the four scaled ratios
  localparam int RI_DET = 0;
  localparam int RI_U   = 1;
  localparam int RI_V   = 2;
  localparam int RI_T   = 3;

endpackage

// ===== hw/rtl/sti_if.sv =====
// Valid/ready channel interfaces for the intersection core: test items,
// results and the threshold write port. Depends on sti_pkg.
interface sti_in_if
  import sti_pkg::*;
#(
  parameter int COORD_WIDTH = STI_COORD_WIDTH
);
  logic                     valid;
  logic                     ready;
  logic [3*COORD_WIDTH-1:0] vertex_a;
  logic [3*COORD_WIDTH-1:0] vertex_b;
  logic [3*COORD_WIDTH-1:0] vertex_c;
  logic [3*COORD_WIDTH-1:0] seg_start;
  logic [3*COORD_WIDTH-1:0] seg_end;

  modport source (
    output valid, vertex_a, vertex_b, vertex_c, seg_start, seg_end,
    input  ready
  );
  modport sink (
    input  valid, vertex_a, vertex_b, vertex_c, seg_start, seg_end,
    output ready
  );
endinterface

interface sti_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] reason;

  modport source (output valid, hit, reason, input ready);
  modport sink (input valid, hit, reason, output ready);
endinterface

interface sti_cfg_if
  import sti_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [STI_THR_WIDTH-1:0] parallel_threshold;

  modport source (output valid, parallel_threshold, input ready);
  modport sink (input valid, parallel_threshold, output ready);
endinterface

// ===== hw/rtl/sti_cross.sv =====
// Front of the pipe: edge/segment differences, then the two cross products
// P = D x E2 and Q = T x E1 over a multiply stage and a subtract stage. Uses sti_pkg.
module sti_cross
  import sti_pkg::*;
#(
  parameter int COORD_WIDTH = STI_COORD_WIDTH,
  localparam int VW  = 3 * COORD_WIDTH,
  localparam int DW  = COORD_WIDTH + 1,
  localparam int PRW = 2 * DW,
  localparam int XW  = PRW + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [VW-1:0]           vertex_a,
  input  logic [VW-1:0]           vertex_b,
  input  logic [VW-1:0]           vertex_c,
  input  logic [VW-1:0]           seg_start,
  input  logic [VW-1:0]           seg_end,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [3:0][2:0][DW-1:0] dif,
  output logic [2:0][XW-1:0]      pv,
  output logic [2:0][XW-1:0]      qv
);

  logic                    va_r, vb_r, vc_r;
  logic                    adv_a, adv_b, adv_c;
  logic [3:0][2:0][DW-1:0] dif_nxt, dif_a_r, dif_b_r, dif_c_r;
  logic [2:0][PRW-1:0]     pa_nxt, pb_nxt, qa_nxt, qb_nxt;
  logic [2:0][PRW-1:0]     pa_r, pb_r, qa_r, qb_r;
  logic [2:0][XW-1:0]      p_nxt, q_nxt, p_r, q_r;

  assign adv_c    = !vc_r || out_ready;
  assign adv_b    = !vb_r || adv_c;
  assign adv_a    = !va_r || adv_b;
  assign in_ready = adv_a;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    logic signed [COORD_WIDTH-1:0] ca, cb, cc, cs, ce;

    assign ca = vertex_a[k*COORD_WIDTH +: COORD_WIDTH];
    assign cb = vertex_b[k*COORD_WIDTH +: COORD_WIDTH];
    assign cc = vertex_c[k*COORD_WIDTH +: COORD_WIDTH];
    assign cs = seg_start[k*COORD_WIDTH +: COORD_WIDTH];
    assign ce = seg_end[k*COORD_WIDTH +: COORD_WIDTH];

    assign dif_nxt[DI_E1][k] = DW'(cb) - DW'(ca);
    assign dif_nxt[DI_E2][k] = DW'(cc) - DW'(ca);
    assign dif_nxt[DI_T][k]  = DW'(cs) - DW'(ca);
    assign dif_nxt[DI_D][k]  = DW'(ce) - DW'(cs);

    assign pa_nxt[k] = $signed(dif_a_r[DI_D][K1]) * $signed(dif_a_r[DI_E2][K2]);
    assign pb_nxt[k] = $signed(dif_a_r[DI_D][K2]) * $signed(dif_a_r[DI_E2][K1]);
    assign qa_nxt[k] = $signed(dif_a_r[DI_T][K1]) * $signed(dif_a_r[DI_E1][K2]);
    assign qb_nxt[k] = $signed(dif_a_r[DI_T][K2]) * $signed(dif_a_r[DI_E1][K1]);

    assign p_nxt[k] = XW'($signed(pa_r[k])) - XW'($signed(pb_r[k]));
    assign q_nxt[k] = XW'($signed(qa_r[k])) - XW'($signed(qb_r[k]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= in_valid;
      if (adv_b) vb_r <= va_r;
      if (adv_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      dif_a_r <= dif_nxt;
    end
    if (adv_b) begin
      dif_b_r <= dif_a_r;
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      qa_r    <= qa_nxt;
      qb_r    <= qb_nxt;
    end
    if (adv_c) begin
      dif_c_r <= dif_b_r;
      p_r     <= p_nxt;
      q_r     <= q_nxt;
    end
  end

  assign out_valid = vc_r;
  assign dif       = dif_c_r;
  assign pv        = p_r;
  assign qv        = q_r;

endmodule

// ===== hw/rtl/sti_dot.sv =====
// Middle of the pipe: the twelve products of det, U, V and t, then the three-term
// sums. Uses sti_pkg for the slot indexes.
module sti_dot
  import sti_pkg::*;
#(
  parameter int COORD_WIDTH = STI_COORD_WIDTH,
  localparam int DW = COORD_WIDTH + 1,
  localparam int XW = 2 * DW + 1,
  localparam int MW = DW + XW,
  localparam int SW = MW + 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [3:0][2:0][DW-1:0] dif,
  input  logic [2:0][XW-1:0]      pv,
  input  logic [2:0][XW-1:0]      qv,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [3:0][SW-1:0]      ratio
);

  logic                    vm_r, vs_r;
  logic                    adv_m, adv_s;
  logic [3:0][2:0][MW-1:0] prod_nxt, prod_r;
  logic [3:0][SW-1:0]      sum_nxt, sum_r;

  assign adv_s    = !vs_r || out_ready;
  assign adv_m    = !vm_r || adv_s;
  assign in_ready = adv_m;

  for (genvar k = 0; k < 3; k++) begin : g_mul
    assign prod_nxt[RI_DET][k] = $signed(dif[DI_E1][k]) * $signed(pv[k]);
    assign prod_nxt[RI_U][k]   = $signed(dif[DI_T][k]) * $signed(pv[k]);
    assign prod_nxt[RI_V][k]   = $signed(dif[DI_D][k]) * $signed(qv[k]);
    assign prod_nxt[RI_T][k]   = $signed(dif[DI_E2][k]) * $signed(qv[k]);
  end

  for (genvar j = 0; j < 4; j++) begin : g_sum
    assign sum_nxt[j] = SW'($signed(prod_r[j][0])) + SW'($signed(prod_r[j][1]))
                      + SW'($signed(prod_r[j][2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vs_r <= 1'b0;
    end else begin
      if (adv_m) vm_r <= in_valid;
      if (adv_s) vs_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_m) prod_r <= prod_nxt;
    if (adv_s) sum_r  <= sum_nxt;
  end

  assign out_valid = vs_r;
  assign ratio     = sum_r;

endmodule

// ===== hw/rtl/sti_classify.sv =====
// Tail of the pipe: sign correction by det, then the parallel, barycentric and
// segment range checks into the result register. Uses sti_pkg.
module sti_classify
  import sti_pkg::*;
#(
  parameter int COORD_WIDTH = STI_COORD_WIDTH,
  localparam int SW   = 3 * COORD_WIDTH + 6,
  localparam int NW   = SW + 1,
  localparam int CMPW = (NW > STI_THR_WIDTH) ? NW : STI_THR_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [3:0][SW-1:0]       ratio,
  input  logic [STI_THR_WIDTH-1:0] threshold,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               reason
);

  logic               vn_r, vr_r;
  logic               adv_n, adv_r;
  logic               flip;
  logic [3:0][NW-1:0] fix_nxt, fix_r;
  logic signed [NW-1:0] det_s, u_s, v_s, t_s;
  logic signed [NW:0]   uv_s;
  logic                 par;
  sti_reason_t          reason_nxt, reason_r;

  assign adv_r    = !vr_r || out_ready;
  assign adv_n    = !vn_r || adv_r;
  assign in_ready = adv_n;

  // Negate all four ratios when det is negative
  assign flip = ratio[RI_DET][SW-1];
  for (genvar j = 0; j < 4; j++) begin : g_fix
    assign fix_nxt[j] = flip ? -NW'($signed(ratio[j])) : NW'($signed(ratio[j]));
  end

  assign det_s = $signed(fix_r[RI_DET]);
  assign u_s   = $signed(fix_r[RI_U]);
  assign v_s   = $signed(fix_r[RI_V]);
  assign t_s   = $signed(fix_r[RI_T]);
  assign uv_s  = (NW+1)'(u_s) + (NW+1)'(v_s);
  assign par   = CMPW'(fix_r[RI_DET]) <= CMPW'(threshold);

  always_comb begin
    if (par) begin
      reason_nxt = RSN_PARALLEL;
    end else if (u_s < 0 || u_s > det_s) begin
      reason_nxt = RSN_OUT_BARY;
    end else if (v_s < 0 || uv_s > (NW+1)'(det_s)) begin
      reason_nxt = RSN_OUT_BARY;
    end else if (t_s > 0 && t_s < det_s) begin
      reason_nxt = RSN_HIT;
    end else begin
      reason_nxt = RSN_OUT_SEG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
      vr_r <= 1'b0;
    end else begin
      if (adv_n) vn_r <= in_valid;
      if (adv_r) vr_r <= vn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_n) fix_r    <= fix_nxt;
    if (adv_r) reason_r <= reason_nxt;
  end

  assign out_valid = vr_r;
  assign reason    = reason_r;

endmodule

// ===== hw/rtl/segment_triangle_intersect_core.sv =====
// Top level of the segment/triangle intersection core: threshold register and
// the three pipeline sections. Depends on sti_pkg, sti_if, sti_cross, sti_dot, sti_classify.
//
//   channel   direction  payload                                        transfer
//   in_ch     sink       vertex_a/b/c, seg_start, seg_end (3 x Q8.8)    valid & ready
//   out_ch    source     hit, reason                                    valid & ready
//   cfg_ch    sink       parallel_threshold (32 bit, reset 1)           valid & ready
//
// Seven register stages: differences, cross multiply, cross subtract, dot multiply,
// dot sum, sign fix, range checks. One item is taken per cycle while out_ch is not
// stalled. Each stage holds while its successor is full and stalled, so out_ch
// back-pressure fills the pipe before in_ch.ready drops. Reset clears the valid
// bits and loads the threshold with 1; cfg_ch is always ready.
module segment_triangle_intersect_core
  import sti_pkg::*;
#(
  parameter int COORD_WIDTH = STI_COORD_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  sti_in_if.sink   in_ch,
  sti_out_if.source out_ch,
  sti_cfg_if.sink  cfg_ch
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int XW = 2 * DW + 1;
  localparam int SW = 3 * COORD_WIDTH + 6;

  logic [STI_THR_WIDTH-1:0] thr_r;
  logic                     x_valid, x_ready, d_valid, d_ready;
  logic [3:0][2:0][DW-1:0]  dif;
  logic [2:0][XW-1:0]       pv, qv;
  logic [3:0][SW-1:0]       ratio;
  logic [1:0]               reason;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= STI_THR_RESET;
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.parallel_threshold;
    end
  end

  sti_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .vertex_a  (in_ch.vertex_a),
    .vertex_b  (in_ch.vertex_b),
    .vertex_c  (in_ch.vertex_c),
    .seg_start (in_ch.seg_start),
    .seg_end   (in_ch.seg_end),
    .out_valid (x_valid),
    .out_ready (x_ready),
    .dif       (dif),
    .pv        (pv),
    .qv        (qv)
  );

  sti_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (x_valid),
    .in_ready  (x_ready),
    .dif       (dif),
    .pv        (pv),
    .qv        (qv),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .ratio     (ratio)
  );

  sti_classify #(.COORD_WIDTH(COORD_WIDTH)) u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .ratio     (ratio),
    .threshold (thr_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .reason    (reason)
  );

  assign out_ch.reason = reason;
  assign out_ch.hit    = (reason == RSN_HIT);

endmodule
